@@ rtl/core/round_robin_delay_scheduler_core_macros.svh @@
// Assertion macros shared by the scheduler core modules.
`ifndef ROUND_ROBIN_DELAY_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_DELAY_SCHEDULER_CORE_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define RRDS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define RRDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rrds_pkg.sv @@
// Package with the types, constants and command structs of the scheduler core.
`default_nettype none

package rrds_pkg;

    localparam int MAX_TASKS    = 8;
    localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W        = $clog2(MAX_TASKS + 1);
    localparam int TASK_INDEX_W = 3;
    localparam int STACK_W      = 32;
    localparam int DELAY_W      = 32;
    localparam int TIME_W       = 64;

    typedef enum logic [1:0] {
        KIND_INSTALL = 2'd0,
        KIND_DELAY   = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_SCHED   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic search;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_search;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/rrds_ctrl.sv @@
// Controller state machine of the scheduler core.
`default_nettype none
`include "round_robin_delay_scheduler_core_macros.svh"

module rrds_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire rrds_pkg::status_t status,
    output rrds_pkg::cmd_t        cmd
);

    rrds_pkg::state_t state_reg;
    rrds_pkg::state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        unique case (state_reg)
            rrds_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = rrds_pkg::ST_EXEC;
                end
            end
            rrds_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.needs_search ? rrds_pkg::ST_SEARCH : rrds_pkg::ST_FINISH;
            end
            rrds_pkg::ST_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = rrds_pkg::ST_FINISH;
            end
            rrds_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = rrds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `RRDS_ASSERT_NEXT(a_accept_starts_exec, in_valid && !in_stall, state_reg == rrds_pkg::ST_EXEC, "accepted item did not start execution")

endmodule

`default_nettype wire

@@ rtl/core/rrds_datapath.sv @@
// Datapath of the scheduler core: task table, time counter, search and result register.
`default_nettype none
`include "round_robin_delay_scheduler_core_macros.svh"

module rrds_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire rrds_pkg::cmd_t                       cmd,
    output rrds_pkg::status_t                         status,
    input  wire logic [1:0]                           kind,
    input  wire logic [rrds_pkg::STACK_W-1:0]         stack_addr,
    input  wire logic [rrds_pkg::DELAY_W-1:0]         delay_ticks,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [rrds_pkg::TASK_INDEX_W-1:0]         task_index,
    output logic [rrds_pkg::STACK_W-1:0]              task_stack,
    output logic                                      any_woken,
    output logic                                      none_ready,
    output logic                                      table_full
);

    localparam int N = rrds_pkg::MAX_TASKS;

    // Captured item.
    rrds_pkg::kind_t                 kind_reg;
    logic [rrds_pkg::STACK_W-1:0]    stk_reg;
    logic [rrds_pkg::DELAY_W-1:0]    dly_reg;

    // Task table and scheduler state.
    logic [N-1:0]                    ready_reg;
    logic [N-1:0]                    ready_next;
    logic [rrds_pkg::TIME_W-1:0]     wake_reg [N];
    logic [rrds_pkg::STACK_W-1:0]    stack_reg [N];
    logic [rrds_pkg::IDX_W-1:0]      cur_reg;
    logic [rrds_pkg::CNT_W-1:0]      count_reg;
    logic [rrds_pkg::TIME_W-1:0]     tick_reg;

    // Per-item flags.
    logic                            woken_reg;
    logic                            none_reg;
    logic                            full_reg;

    // Result register.
    logic                            out_valid_reg;
    logic [rrds_pkg::TASK_INDEX_W-1:0] out_index_reg;
    logic [rrds_pkg::STACK_W-1:0]    out_stack_reg;
    logic                            out_woken_reg;
    logic                            out_none_reg;
    logic                            out_full_reg;

    logic [rrds_pkg::TIME_W-1:0]     tick_inc;
    logic [rrds_pkg::TIME_W-1:0]     wake_sum;
    logic [N-1:0]                    installed;
    logic [N-1:0]                    woken_vec;
    logic                            has_room;
    logic [rrds_pkg::IDX_W-1:0]      slot;
    logic                            hi_found;
    logic                            lo_found;
    logic [rrds_pkg::IDX_W-1:0]      hi_idx;
    logic [rrds_pkg::IDX_W-1:0]      lo_idx;

    assign tick_inc = tick_reg + rrds_pkg::TIME_W'(1);
    assign wake_sum = tick_reg + rrds_pkg::TIME_W'(dly_reg);
    assign has_room = (count_reg < rrds_pkg::CNT_W'(N));
    assign slot     = count_reg[rrds_pkg::IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            installed[i] = (rrds_pkg::CNT_W'(i) < count_reg);
            woken_vec[i] = installed[i] && (wake_reg[i] == tick_inc);
        end
    end

    // Round-robin pick: the lowest ready task above the current one wins,
    // otherwise the lowest ready task at or below it (the current one last).
    always_comb
    begin
        hi_found = 1'b0;
        lo_found = 1'b0;
        hi_idx   = '0;
        lo_idx   = '0;
        for (int j = N - 1; j >= 0; j--)
        begin
            if (ready_reg[j] && installed[j])
            begin
                if (rrds_pkg::IDX_W'(j) > cur_reg)
                begin
                    hi_found = 1'b1;
                    hi_idx   = rrds_pkg::IDX_W'(j);
                end
                else
                begin
                    lo_found = 1'b1;
                    lo_idx   = rrds_pkg::IDX_W'(j);
                end
            end
        end
    end

    always_comb
    begin
        ready_next = ready_reg;
        if (cmd.exec)
        begin
            case (kind_reg)
                rrds_pkg::KIND_INSTALL:
                begin
                    if (has_room)
                    begin
                        ready_next[slot] = 1'b1;
                    end
                end
                rrds_pkg::KIND_DELAY:
                begin
                    ready_next[cur_reg] = 1'b0;
                end
                rrds_pkg::KIND_TICK:
                begin
                    ready_next = ready_reg | woken_vec;
                end
                default:
                begin
                    ready_next = ready_reg;
                end
            endcase
        end
    end

    assign status.needs_search = (kind_reg == rrds_pkg::KIND_DELAY) ||
                                 (kind_reg == rrds_pkg::KIND_SCHED);
    assign status.out_free     = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            cur_reg   <= '0;
            count_reg <= '0;
            tick_reg  <= '0;
            woken_reg <= 1'b0;
            none_reg  <= 1'b0;
            full_reg  <= 1'b0;
            kind_reg  <= rrds_pkg::KIND_INSTALL;
            for (int i = 0; i < N; i++)
            begin
                wake_reg[i] <= '0;
            end
        end
        else
        begin
            ready_reg <= ready_next;
            if (cmd.capture)
            begin
                kind_reg  <= rrds_pkg::kind_t'(kind);
                woken_reg <= 1'b0;
                none_reg  <= 1'b0;
                full_reg  <= 1'b0;
            end
            if (cmd.exec)
            begin
                case (kind_reg)
                    rrds_pkg::KIND_INSTALL:
                    begin
                        if (has_room)
                        begin
                            wake_reg[slot] <= '0;
                            count_reg      <= count_reg + rrds_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            full_reg <= 1'b1;
                        end
                    end
                    rrds_pkg::KIND_DELAY:
                    begin
                        wake_reg[cur_reg] <= wake_sum;
                    end
                    rrds_pkg::KIND_TICK:
                    begin
                        tick_reg  <= tick_inc;
                        woken_reg <= |woken_vec;
                    end
                    default:
                    begin
                        tick_reg <= tick_reg;
                    end
                endcase
            end
            if (cmd.search)
            begin
                if (hi_found)
                begin
                    cur_reg <= hi_idx;
                end
                else if (lo_found)
                begin
                    cur_reg <= lo_idx;
                end
                else
                begin
                    none_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            stk_reg <= stack_addr;
            dly_reg <= delay_ticks;
        end
        if (cmd.exec && (kind_reg == rrds_pkg::KIND_INSTALL) && has_room)
        begin
            stack_reg[slot] <= stk_reg;
        end
        if (cmd.load_out)
        begin
            out_index_reg <= rrds_pkg::TASK_INDEX_W'(cur_reg);
            out_stack_reg <= (count_reg == '0) ? '0 : stack_reg[cur_reg];
            out_woken_reg <= woken_reg;
            out_none_reg  <= none_reg;
            out_full_reg  <= full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign task_index = out_index_reg;
    assign task_stack = out_stack_reg;
    assign any_woken  = out_woken_reg;
    assign none_ready = out_none_reg;
    assign table_full = out_full_reg;

    `RRDS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= rrds_pkg::CNT_W'(N), "task count above table size")
    `RRDS_ASSERT_SAME(a_cur_installed, count_reg != '0, rrds_pkg::CNT_W'(cur_reg) < count_reg, "current task not installed")
    `RRDS_ASSERT_SAME(a_load_free, cmd.load_out, !out_valid_reg || !out_stall, "result overwrote a pending item")

endmodule

`default_nettype wire

@@ rtl/core/round_robin_delay_scheduler_core.sv @@
// Top level of the round-robin task scheduler core with tick delays.
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid / in_stall  kind, stack_addr, delay_ticks
//   output   out        out_valid/out_stall  task_index, task_stack, any_woken,
//                                            none_ready, table_full
//
// An install or tick item goes from the execute state to the finish state, where
// it is loaded into the output register; a delay or schedule item also passes
// through the search state between them, the round-robin search over the ready
// bits, which runs after the table update of the execute state. The controller
// returns to idle after the load, so a new item is taken only once the last one
// is loaded. One item is in work at a time; a finished result sits in the output
// register while the next item is accepted and executed, and only the final load
// waits on a stalled output.
// Reset clears the ready bits, wake times, current task, task count and time.
`default_nettype none

module round_robin_delay_scheduler_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           kind,
    input  wire logic [rrds_pkg::STACK_W-1:0]         stack_addr,
    input  wire logic [rrds_pkg::DELAY_W-1:0]         delay_ticks,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [rrds_pkg::TASK_INDEX_W-1:0]         task_index,
    output logic [rrds_pkg::STACK_W-1:0]              task_stack,
    output logic                                      any_woken,
    output logic                                      none_ready,
    output logic                                      table_full
);

    // The controller sequences capture, execute, search and result load;
    // the datapath holds all task state and reports whether a search is due
    // and whether the output register can take a new result.
    rrds_pkg::cmd_t    cmd;
    rrds_pkg::status_t status;

    rrds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rrds_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (kind),
        .stack_addr  (stack_addr),
        .delay_ticks (delay_ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .task_index  (task_index),
        .task_stack  (task_stack),
        .any_woken   (any_woken),
        .none_ready  (none_ready),
        .table_full  (table_full)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the round-robin delay scheduler core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrds_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    // One result of the scheduler, in port order.
    typedef struct packed {
        logic [TASK_INDEX_W-1:0] idx;
        logic [STACK_W-1:0]      stk;
        logic                    woken;
        logic                    none;
        logic                    full;
    } sched_result_t;

    // One row of the directed table. When typed is set, res holds the result
    // read straight off the spec and replaces the predicted one.
    typedef struct {
        kind_t               k;
        logic [STACK_W-1:0]  stk;
        logic [DELAY_W-1:0]  dly;
        bit                  typed;
        sched_result_t       res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] kind = KIND_INSTALL;
    logic [STACK_W-1:0] stack_addr = '0;
    logic [DELAY_W-1:0] delay_ticks = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [TASK_INDEX_W-1:0] task_index;
    logic [STACK_W-1:0] task_stack;
    logic any_woken;
    logic none_ready;
    logic table_full;

    // Scheduler state as the predictor sees it.
    logic               tk_ready [MAX_TASKS];
    logic [TIME_W-1:0]  tk_wake [MAX_TASKS];
    logic [STACK_W-1:0] tk_stack [MAX_TASKS];
    logic [IDX_W-1:0]   cur_task;
    int                 n_tasks;
    logic [TIME_W-1:0]  now_ticks;

    sched_result_t pending_results[$];
    stim_row_t     directed_rows[24];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            stall_left = 0;
    bit            send_pace = 1'b1;
    bit            recv_pace = 1'b1;

    round_robin_delay_scheduler_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .stack_addr  (stack_addr),
        .delay_ticks (delay_ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .task_index  (task_index),
        .task_stack  (task_stack),
        .any_woken   (any_woken),
        .none_ready  (none_ready),
        .table_full  (table_full)
    );

    always #5 clk = ~clk;

    // Round-robin search starting after the current task and ending with it.
    function automatic bit rr_advance();
        int cand;
        cand = int'(cur_task);
        for (int n = 0; n < n_tasks; n++)
        begin
            cand = cand + 1;
            if (cand >= n_tasks)
                cand = 0;
            if (tk_ready[cand])
            begin
                cur_task = IDX_W'(cand);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one kernel event to the predicted state and returns its result.
    function automatic sched_result_t sched_predict(input kind_t k,
                                                    input logic [STACK_W-1:0] s,
                                                    input logic [DELAY_W-1:0] d);
        sched_result_t r;
        r = '0;
        case (k)
            KIND_INSTALL:
            begin
                if (n_tasks < MAX_TASKS)
                begin
                    tk_stack[n_tasks] = s;
                    tk_ready[n_tasks] = 1'b1;
                    tk_wake[n_tasks]  = '0;
                    n_tasks++;
                end
                else
                    r.full = 1'b1;
            end
            KIND_DELAY:
            begin
                // Even with an empty table the entry of task 0 is written.
                tk_wake[cur_task]  = now_ticks + TIME_W'(d);
                tk_ready[cur_task] = 1'b0;
                r.none = !rr_advance();
            end
            KIND_TICK:
            begin
                now_ticks = now_ticks + TIME_W'(1);
                for (int i = 0; i < n_tasks; i++)
                begin
                    if (tk_wake[i] == now_ticks)
                    begin
                        tk_ready[i] = 1'b1;
                        r.woken = 1'b1;
                    end
                end
            end
            default:
                r.none = !rr_advance();
        endcase
        r.idx = cur_task;
        r.stk = (n_tasks == 0) ? '0 : tk_stack[cur_task];
        return r;
    endfunction

    // Presents one item, waits for it to be taken and records what it should
    // produce. Valid is only lowered when a gap actually follows.
    task automatic send_item(input kind_t k, input logic [STACK_W-1:0] s,
                             input logic [DELAY_W-1:0] d, input bit typed,
                             input sched_result_t typed_res);
        int gap;
        sched_result_t predicted;
        gap = send_pace ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        stack_addr  <= s;
        delay_ticks <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = sched_predict(k, s, d);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Result checker and output-side stall generator.
    always @(posedge clk)
    begin
        sched_result_t want;
        bit bad;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: idx=%0d stack=%h woken=%b none=%b full=%b",
                             task_index, task_stack, any_woken, none_ready, table_full);
            end
            else
            begin
                want = pending_results.pop_front();
                bad = (task_index !== want.idx) || (task_stack !== want.stk) ||
                      (any_woken !== want.woken) || (none_ready !== want.none) ||
                      (table_full !== want.full);
                if (bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: exp idx=%0d stack=%h woken=%b none=%b full=%b",
                                 want.idx, want.stk, want.woken, want.none, want.full);
                        $display("          got idx=%0d stack=%h woken=%b none=%b full=%b",
                                 task_index, task_stack, any_woken, none_ready, table_full);
                    end
                end
            end
            stall_left = recv_pace ? $urandom_range(0, 7) : 0;
        end
        else if (stall_left > 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[round_robin_delay_scheduler_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int dsel;
        kind_t k;
        logic [DELAY_W-1:0] d;

        for (int i = 0; i < MAX_TASKS; i++)
        begin
            tk_ready[i] = 1'b0;
            tk_wake[i]  = '0;
            tk_stack[i] = '0;
        end
        cur_task  = '0;
        n_tasks   = 0;
        now_ticks = '0;

        // Empty table first: search misses, a delay still writes entry 0,
        // a zero delay there, then a single task that only finds itself.
        directed_rows[0]  = '{KIND_SCHED, 32'h0, 32'h0, 1'b1,
                              {3'd0, 32'h0, 1'b0, 1'b1, 1'b0}};
        directed_rows[1]  = '{KIND_DELAY, 32'h0, 32'hFFFF_FFFF, 1'b1,
                              {3'd0, 32'h0, 1'b0, 1'b1, 1'b0}};
        directed_rows[2]  = '{KIND_TICK, 32'h0, 32'h0, 1'b1,
                              {3'd0, 32'h0, 1'b0, 1'b0, 1'b0}};
        directed_rows[3]  = '{KIND_DELAY, 32'h0, 32'h0, 1'b1,
                              {3'd0, 32'h0, 1'b0, 1'b1, 1'b0}};
        directed_rows[4]  = '{KIND_INSTALL, 32'hFFFF_FFFF, 32'h0, 1'b1,
                              {3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}};
        directed_rows[5]  = '{KIND_SCHED, 32'h0, 32'h0, 1'b1,
                              {3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}};
        // Fill the table, then one install too many.
        directed_rows[6]  = '{KIND_INSTALL, 32'h0000_0000, 32'h0, 1'b0, '0};
        directed_rows[7]  = '{KIND_INSTALL, 32'h5A5A_A5A5, 32'h0, 1'b0, '0};
        directed_rows[8]  = '{KIND_INSTALL, 32'h0F0F_0F0F, 32'h0, 1'b0, '0};
        directed_rows[9]  = '{KIND_INSTALL, 32'h1234_5678, 32'h0, 1'b0, '0};
        directed_rows[10] = '{KIND_INSTALL, 32'h8000_0000, 32'h0, 1'b0, '0};
        directed_rows[11] = '{KIND_INSTALL, 32'h7FFF_FFFF, 32'h0, 1'b0, '0};
        directed_rows[12] = '{KIND_INSTALL, 32'h0000_0001, 32'h0, 1'b0, '0};
        directed_rows[13] = '{KIND_INSTALL, 32'h1357_9BDF, 32'h0, 1'b1,
                              {3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1}};
        // Zero delay on task 1 never matches again; tasks 2 and 3 wake on time.
        directed_rows[14] = '{KIND_SCHED, 32'h0, 32'h0, 1'b0, '0};
        directed_rows[15] = '{KIND_DELAY, 32'h0, 32'h0, 1'b0, '0};
        directed_rows[16] = '{KIND_DELAY, 32'h0, 32'h1, 1'b0, '0};
        directed_rows[17] = '{KIND_DELAY, 32'h0, 32'h3, 1'b0, '0};
        directed_rows[18] = '{KIND_TICK, 32'h0, 32'h0, 1'b0, '0};
        directed_rows[19] = '{KIND_TICK, 32'h0, 32'h0, 1'b0, '0};
        directed_rows[20] = '{KIND_TICK, 32'h0, 32'h0, 1'b0, '0};
        directed_rows[21] = '{KIND_SCHED, 32'h0, 32'h0, 1'b0, '0};
        directed_rows[22] = '{KIND_DELAY, 32'h0, 32'h8000_0000, 1'b0, '0};
        directed_rows[23] = '{KIND_TICK, 32'h0, 32'h0, 1'b0, '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].k, directed_rows[i].stk, directed_rows[i].dly,
                      directed_rows[i].typed, directed_rows[i].res);

        // Random part. Delays are mostly short so that ticks keep waking
        // tasks; zero and full-range delays are rare because such a task
        // sleeps for good unless it is delayed again while current.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                send_pace = ((i / 100) % 2) == 0;
                recv_pace = ((i / 200) % 2) == 0;
            end
            if (i == RANDOM_ITEMS / 2)
            begin
                // Hold off the sender until every outstanding result is back.
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 6)
                k = KIND_INSTALL;
            else if (pick < 36)
                k = KIND_DELAY;
            else if (pick < 70)
                k = KIND_TICK;
            else
                k = KIND_SCHED;
            dsel = $urandom_range(0, 99);
            if (dsel == 0)
                d = '0;
            else if (dsel == 1)
                d = $urandom;
            else
                d = $urandom_range(1, 10);
            send_item(k, $urandom, d, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[round_robin_delay_scheduler_core] OK");
        else
            $display("[round_robin_delay_scheduler_core] ERROR");
        $finish;
    end

endmodule
